// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker module of the tilt filter.
// Needs nothing else; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define GCTF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is high.
`define GCTF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/gctf_pkg.sv =====
// Package of the gated complementary tilt filter: widths, fixed-point
// constants, register indexes, the CORDIC angle table and the cell type.
// Depends on nothing.
`default_nettype none

package gctf_pkg;

   // Datapath widths of the CORDIC chain.
   localparam int unsigned DATA_W = 28;
   localparam int unsigned ANG_W  = 21;
   localparam int unsigned ACC_W  = 18;

   localparam int unsigned CORDIC_STEPS_DEF = 16;
   localparam int unsigned TABLE_LEN        = 24;

   // Fixed-point constants.
   localparam logic signed [ANG_W-1:0] PI_Q16       = 21'sd205887;
   localparam int                      PI_Q13       = 25736;
   localparam int                      TWO_PI_Q13   = 51472;
   localparam logic [15:0]             INV_GAIN_Q16 = 16'd39797;
   localparam int                      ONE_G_SCALED = 1048576;
   localparam logic [23:0]             GYRO_K       = 24'd9825330;
   localparam logic [11:0]             GYRO_K_HI    = GYRO_K[23:12];
   localparam logic [11:0]             GYRO_K_LO    = GYRO_K[11:0];
   // 2^44 / 15625 rounded up; exact for every dividend below 2^30.
   localparam logic [30:0]             K_RECIP      = 31'd1125899907;
   localparam logic [40:0]             K_SAT_LEVEL  = 41'd65536000000;
   localparam logic [40:0]             K_ROUND      = 41'd500000;

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_GATE_BAND = 2'd0;
   localparam logic [1:0] REG_GAIN      = 2'd1;
   localparam logic [1:0] REG_TILT      = 2'd2;

   // Data handed from one CORDIC cell to the next.
   typedef struct packed {
      logic                    vld;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [ANG_W-1:0]  z;
   } cordic_type;

   // atan(2^-i) in 2^-16 rad, rounded.
   function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         5'd0:    v = 21'sd51472;
         5'd1:    v = 21'sd30386;
         5'd2:    v = 21'sd16055;
         5'd3:    v = 21'sd8150;
         5'd4:    v = 21'sd4091;
         5'd5:    v = 21'sd2047;
         5'd6:    v = 21'sd1024;
         5'd7:    v = 21'sd512;
         5'd8:    v = 21'sd256;
         5'd9:    v = 21'sd128;
         5'd10:   v = 21'sd64;
         5'd11:   v = 21'sd32;
         5'd12:   v = 21'sd16;
         5'd13:   v = 21'sd8;
         5'd14:   v = 21'sd4;
         5'd15:   v = 21'sd2;
         5'd16:   v = 21'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/gctf_req_if.sv =====
// Input channel of the tilt filter: one IMU sample per item.
// Depends on nothing.
`default_nettype none

interface gctf_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] rate_x;
   logic signed [15:0] rate_y;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] linear_accel;
   logic        [15:0] step_time;

   modport source (output valid, rate_x, rate_y, accel_x, accel_y, accel_z,
                   linear_accel, step_time, input ready);
   modport sink (input valid, rate_x, rate_y, accel_x, accel_y, accel_z,
                 linear_accel, step_time, output ready);
endinterface

`default_nettype wire

// ===== rtl/gctf_rsp_if.sv =====
// Result channel of the tilt filter: angles and flags, one item per sample.
// Depends on nothing.
`default_nettype none

interface gctf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] pitch_angle;
   logic signed [14:0] roll_angle;
   logic               accel_used;
   logic               sample_taken;

   modport source (output valid, pitch_angle, roll_angle, accel_used,
                   sample_taken, input ready);
   modport sink (input valid, pitch_angle, roll_angle, accel_used,
                 sample_taken, output ready);
endinterface

`default_nettype wire

// ===== rtl/gctf_cordic_cell.sv =====
// One vectoring CORDIC iteration with its output register.
// Depends on gctf_pkg.
`default_nettype none

module gctf_cordic_cell
   import gctf_pkg::*;
#(
   parameter int unsigned SHIFT = 0
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cordic_type cell_in,
   output cordic_type      cell_out
);

   localparam logic signed [ANG_W-1:0] ATAN = atan_entry(5'(SHIFT));

   logic signed [DATA_W-1:0] xs;
   logic signed [DATA_W-1:0] ys;
   cordic_type               out_in;
   cordic_type               out_ff;

   // Rotate toward the x axis by the sign of y.
   always_comb begin
      xs         = cell_in.x >>> SHIFT;
      ys         = cell_in.y >>> SHIFT;
      out_in.vld = cell_in.vld;
      if (!cell_in.y[DATA_W-1]) begin
         out_in.x = cell_in.x + ys;
         out_in.y = cell_in.y - xs;
         out_in.z = cell_in.z + ATAN;
      end else begin
         out_in.x = cell_in.x - ys;
         out_in.y = cell_in.y + xs;
         out_in.z = cell_in.z - ATAN;
      end
   end

   // The valid bit is reset; the payload is not.
   always_ff @(posedge clock) begin
      out_ff.x <= out_in.x;
      out_ff.y <= out_in.y;
      out_ff.z <= out_in.z;
      if (reset) begin
         out_ff.vld <= 1'b0;
      end else begin
         out_ff.vld <= out_in.vld;
      end
   end

   assign cell_out = out_ff;

endmodule

`default_nettype wire

// ===== rtl/gctf_cordic.sv =====
// Vectoring CORDIC: pre-rotation stage, a chain of iteration cells and a
// gain-removal stage. Depends on gctf_pkg and gctf_cordic_cell.
`default_nettype none

module gctf_cordic
   import gctf_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [DATA_W-1:0] x_in,
   input  wire logic signed [DATA_W-1:0] y_in,
   output logic                          done,
   output logic signed [ACC_W-1:0]       angle,
   output logic        [DATA_W-2:0]      radius
);

   cordic_type chain [CORDIC_STEPS+1];
   cordic_type pre_in;
   cordic_type pre_ff;

   logic [DATA_W-2:0]        xc;
   logic [DATA_W+14:0]       prod_in;
   logic [DATA_W+14:0]       prod_ff;
   logic signed [ANG_W-1:0]  z_ff;
   logic                     post_vld_ff;
   logic [ANG_W-1:0]         zmag;
   logic [ANG_W-1:0]         zrnd;
   logic [DATA_W+14:0]       rad_sum;
   logic signed [ACC_W-1:0]  angle_in;
   logic signed [ACC_W-1:0]  angle_ff;
   logic [DATA_W-2:0]        radius_ff;
   logic                     done_ff;

   // Vectors in the left half plane are turned by pi first.
   always_comb begin
      pre_in.vld = start;
      pre_in.x   = x_in;
      pre_in.y   = y_in;
      pre_in.z   = '0;
      if (x_in[DATA_W-1]) begin
         pre_in.x = -x_in;
         pre_in.y = -y_in;
         pre_in.z = y_in[DATA_W-1] ? -PI_Q16 : PI_Q16;
      end
   end

   always_ff @(posedge clock) begin
      pre_ff.x <= pre_in.x;
      pre_ff.y <= pre_in.y;
      pre_ff.z <= pre_in.z;
      if (reset) begin
         pre_ff.vld <= 1'b0;
      end else begin
         pre_ff.vld <= pre_in.vld;
      end
   end

   assign chain[0] = pre_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      gctf_cordic_cell #(.SHIFT(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   // Scale the radius by the inverse CORDIC gain.
   always_comb begin
      xc      = chain[CORDIC_STEPS].x[DATA_W-1] ? '0 : chain[CORDIC_STEPS].x[DATA_W-2:0];
      prod_in = (DATA_W+15)'(xc) * (DATA_W+15)'(INV_GAIN_Q16);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      z_ff    <= chain[CORDIC_STEPS].z;
      if (reset) begin
         post_vld_ff <= 1'b0;
      end else begin
         post_vld_ff <= chain[CORDIC_STEPS].vld;
      end
   end

   // Round the radius and turn the angle into Q2.13, ties away from zero.
   always_comb begin
      rad_sum  = prod_ff + (DATA_W+15)'(32768);
      zmag     = z_ff[ANG_W-1] ? ANG_W'(-z_ff) : ANG_W'(z_ff);
      zrnd     = (zmag + ANG_W'(4)) >> 3;
      angle_in = z_ff[ANG_W-1] ? -ACC_W'(zrnd) : ACC_W'(zrnd);
   end

   always_ff @(posedge clock) begin
      angle_ff  <= angle_in;
      radius_ff <= rad_sum[DATA_W+14:16];
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= post_vld_ff;
      end
   end

   assign done   = done_ff;
   assign angle  = angle_ff;
   assign radius = radius_ff;

endmodule

`default_nettype wire

// ===== rtl/gated_complementary_tilt_filter.sv =====
// Gated complementary tilt filter. Each accepted item is one IMU sample; each
// gives exactly one result item with the pitch and roll after the sample. A
// sample with zero step time goes straight to the done state and leaves the
// filter state alone. Any other sample runs through gyro integration (states
// GYRO1 to GYRO3), then makes two passes through the chain of CORDIC cells,
// roll first and pitch second, and then the gated correction (states GATE,
// MULT and APPLY). One sample is in work at a time; a finished result waits
// in the output register while the next sample is accepted. For configuration
// writes to take effect for the next sample, the user must make them while
// no sample is in work; the block itself does not enforce this.
`default_nettype none

module gated_complementary_tilt_filter
   import gctf_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   gctf_req_if.sink         req_chan,
   gctf_rsp_if.source       rsp_chan,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_GYRO1 = 10'b0000000010,
      S_GYRO2 = 10'b0000000100,
      S_GYRO3 = 10'b0000001000,
      S_ROLL  = 10'b0000010000,
      S_PITCH = 10'b0000100000,
      S_GATE  = 10'b0001000000,
      S_MULT  = 10'b0010000000,
      S_APPLY = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   localparam int unsigned CL_W = 23;

   function automatic logic signed [15:0] clamp_tilt(input logic signed [CL_W-1:0] a,
                                                     input logic [13:0] lim);
      logic signed [CL_W-1:0] l;
      logic signed [15:0]     r;
      l = CL_W'(lim);
      if (a > l)       r = 16'(l);
      else if (a < -l) r = 16'(-l);
      else             r = 16'(a);
      return r;
   endfunction

   function automatic logic signed [18:0] wrap_err(input logic signed [18:0] e);
      logic signed [18:0] r;
      r = e;
      if (e > 19'(PI_Q13))       r = e - 19'(TWO_PI_Q13);
      else if (e < -19'(PI_Q13)) r = e + 19'(TWO_PI_Q13);
      return r;
   endfunction

   state_type st_ff, st_in;

   // Configuration registers.
   logic [12:0] gate_band_ff;
   logic [15:0] gain_ff;
   logic [13:0] tilt_ff;

   // Filter state.
   logic signed [15:0] pitch_est_ff, pitch_est_in;
   logic signed [15:0] roll_est_ff, roll_est_in;

   // Captured sample.
   logic signed [15:0] rx_ff, ry_ff, ax_ff, ay_ff, az_ff, lin_ff;
   logic        [15:0] dt_ff;

   // Gyro integration.
   logic signed [32:0] gpx_ff, gpy_ff;
   logic        [31:0] mx, my;
   logic        [43:0] ghx_ff, glx_ff, ghy_ff, gly_ff;
   logic               sgx_ff, sgy_ff;
   logic        [56:0] sumx, sumy;
   logic signed [CL_W-1:0] incx, incy;

   // Correction factor division.
   logic [31:0] gd_ff;
   logic [40:0] knum;
   logic [29:0] kdiv_ff;
   logic [59:0] kprod_ff;
   logic        sat_ff;
   logic [16:0] k_val;

   // CORDIC and correction.
   logic                     c_start;
   logic signed [DATA_W-1:0] c_x, c_y;
   logic                     c_done;
   logic signed [ACC_W-1:0]  c_angle;
   logic [DATA_W-2:0]        c_radius;
   logic signed [17:0]       nax;
   logic signed [ACC_W-1:0]  roll_acc_ff, pitch_acc_ff;
   logic signed [DATA_W:0]   dev;
   logic [DATA_W:0]          dev_abs;
   logic                     gate_ok_ff;
   logic signed [18:0]       err_p_ff, err_r_ff;
   logic signed [36:0]       cp_ff, cr_ff;
   logic [36:0]              mp, mr;
   logic [36:0]              rp, rr;
   logic signed [CL_W-1:0]   corr_p, corr_r;
   logic                     used_ff, taken_ff;

   logic               rsp_valid_ff;
   logic signed [14:0] rsp_pitch_ff, rsp_roll_ff;
   logic               rsp_used_ff, rsp_taken_ff;
   logic               rsp_load;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         gate_band_ff <= 13'd410;
         gain_ff      <= 16'd256;
         tilt_ff      <= 14'd6434;
      end else if (csr_we) begin
         case (csr_index)
            REG_GATE_BAND: gate_band_ff <= csr_wdata[12:0];
            REG_GAIN:      gain_ff      <= csr_wdata;
            REG_TILT:      tilt_ff      <= csr_wdata[13:0];
            default:       ;
         endcase
      end
   end

   assign req_chan.ready = (st_ff == S_IDLE);

   // Sample capture.
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         rx_ff  <= req_chan.rate_x;
         ry_ff  <= req_chan.rate_y;
         ax_ff  <= req_chan.accel_x;
         ay_ff  <= req_chan.accel_y;
         az_ff  <= req_chan.accel_z;
         lin_ff <= req_chan.linear_accel;
         dt_ff  <= req_chan.step_time;
      end
   end

   // Gyro products, split so that no multiplier exceeds 32 bits.
   always_comb begin
      mx   = gpx_ff[32] ? 32'(-gpx_ff) : 32'(gpx_ff);
      my   = gpy_ff[32] ? 32'(-gpy_ff) : 32'(gpy_ff);
      sumx = {1'b0, ghx_ff, 12'b0} + 57'(glx_ff) + (57'(1) << 39);
      sumy = {1'b0, ghy_ff, 12'b0} + 57'(gly_ff) + (57'(1) << 39);
      incx = sgx_ff ? -CL_W'(sumx[55:40]) : CL_W'(sumx[55:40]);
      incy = sgy_ff ? -CL_W'(sumy[55:40]) : CL_W'(sumy[55:40]);
   end

   always_ff @(posedge clock) begin
      gpx_ff <= $signed(rx_ff) * $signed({1'b0, dt_ff});
      gpy_ff <= $signed(ry_ff) * $signed({1'b0, dt_ff});
      gd_ff  <= gain_ff * dt_ff;
      ghx_ff <= 44'(mx) * 44'(GYRO_K_HI);
      glx_ff <= 44'(mx) * 44'(GYRO_K_LO);
      ghy_ff <= 44'(my) * 44'(GYRO_K_HI);
      gly_ff <= 44'(my) * 44'(GYRO_K_LO);
      sgx_ff <= gpx_ff[32];
      sgy_ff <= gpy_ff[32];
   end

   // Correction factor k = round(gain * dt * 256 / 1e6). The divide by 64 is
   // a shift and the divide by 15625 is a reciprocal multiplication, which is
   // exact over the whole unsaturated range.
   assign knum  = {1'b0, gd_ff, 8'b0} + K_ROUND;
   assign k_val = sat_ff ? 17'd65536 : {1'b0, kprod_ff[59:44]};

   always_ff @(posedge clock) begin
      if (st_ff == S_GYRO2) begin
         sat_ff  <= (knum >= K_SAT_LEVEL);
         kdiv_ff <= knum[35:6];
      end
      kprod_ff <= 60'(kdiv_ff) * 60'(K_RECIP);
   end

   // CORDIC inputs: roll pass from the accel y/z pair, pitch pass from the
   // horizontal radius and the corrected longitudinal accel.
   always_comb begin
      nax     = -(18'(ax_ff) - 18'(lin_ff));
      c_start = (st_ff == S_GYRO3) || (st_ff == S_ROLL && c_done);
      if (st_ff == S_GYRO3) begin
         c_x = {{(DATA_W-24){az_ff[15]}}, az_ff, 8'b0};
         c_y = {{(DATA_W-24){ay_ff[15]}}, ay_ff, 8'b0};
      end else begin
         c_x = {1'b0, c_radius};
         c_y = {{(DATA_W-26){nax[17]}}, nax, 8'b0};
      end
   end

   gctf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (c_start),
      .x_in   (c_x),
      .y_in   (c_y),
      .done   (c_done),
      .angle  (c_angle),
      .radius (c_radius)
   );

   // Gate on the accel magnitude.
   always_comb begin
      dev     = $signed({2'b0, c_radius}) - (DATA_W+1)'(ONE_G_SCALED);
      dev_abs = dev[DATA_W] ? (DATA_W+1)'(-dev) : (DATA_W+1)'(dev);
   end

   // Rounded corrections.
   always_comb begin
      mp     = cp_ff[36] ? 37'(-cp_ff) : 37'(cp_ff);
      mr     = cr_ff[36] ? 37'(-cr_ff) : 37'(cr_ff);
      rp     = (mp + 37'(32768)) >> 16;
      rr     = (mr + 37'(32768)) >> 16;
      corr_p = cp_ff[36] ? -CL_W'(rp) : CL_W'(rp);
      corr_r = cr_ff[36] ? -CL_W'(rr) : CL_W'(rr);
   end

   always_ff @(posedge clock) begin
      if (st_ff == S_ROLL && c_done) begin
         roll_acc_ff <= c_angle;
      end
      if (st_ff == S_PITCH && c_done) begin
         pitch_acc_ff <= c_angle;
         gate_ok_ff   <= (dev_abs <= (DATA_W+1)'({gate_band_ff, 8'b0}));
      end
      err_p_ff <= wrap_err(19'(pitch_acc_ff) - 19'(pitch_est_ff));
      err_r_ff <= wrap_err(19'(roll_acc_ff) - 19'(roll_est_ff));
      cp_ff    <= $signed({1'b0, k_val}) * err_p_ff;
      cr_ff    <= $signed({1'b0, k_val}) * err_r_ff;
   end

   // Sequencer and state update.
   always_comb begin
      st_in        = st_ff;
      pitch_est_in = pitch_est_ff;
      roll_est_in  = roll_est_ff;
      rsp_load     = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               st_in = (req_chan.step_time == '0) ? S_DONE : S_GYRO1;
            end
         end
         S_GYRO1: st_in = S_GYRO2;
         S_GYRO2: st_in = S_GYRO3;
         S_GYRO3: begin
            pitch_est_in = clamp_tilt(CL_W'(pitch_est_ff) + incy, tilt_ff);
            roll_est_in  = clamp_tilt(CL_W'(roll_est_ff) + incx, tilt_ff);
            st_in        = S_ROLL;
         end
         S_ROLL:  if (c_done) st_in = S_PITCH;
         S_PITCH: if (c_done) st_in = S_GATE;
         S_GATE:  st_in = S_MULT;
         S_MULT:  st_in = S_APPLY;
         S_APPLY: begin
            if (gate_ok_ff) begin
               pitch_est_in = clamp_tilt(CL_W'(pitch_est_ff) + corr_p, tilt_ff);
               roll_est_in  = clamp_tilt(CL_W'(roll_est_ff) + corr_r, tilt_ff);
            end
            st_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               st_in    = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         pitch_est_ff <= '0;
         roll_est_ff  <= '0;
         used_ff      <= 1'b0;
         taken_ff     <= 1'b0;
      end else begin
         st_ff        <= st_in;
         pitch_est_ff <= pitch_est_in;
         roll_est_ff  <= roll_est_in;
         if (st_ff == S_IDLE && req_chan.valid) begin
            used_ff  <= 1'b0;
            taken_ff <= (req_chan.step_time != '0);
         end else if (st_ff == S_APPLY) begin
            used_ff <= gate_ok_ff;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_pitch_ff <= pitch_est_ff[14:0];
         rsp_roll_ff  <= roll_est_ff[14:0];
         rsp_used_ff  <= used_ff;
         rsp_taken_ff <= taken_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.pitch_angle  = rsp_pitch_ff;
   assign rsp_chan.roll_angle   = rsp_roll_ff;
   assign rsp_chan.accel_used   = rsp_used_ff;
   assign rsp_chan.sample_taken = rsp_taken_ff;

endmodule

`default_nettype wire

// ===== rtl/gctf_checker.sv =====
// Port-level checks of the tilt filter, bound to the top level.
// Depends on assert_macros.svh and gated_complementary_tilt_filter.
`default_nettype none
`include "assert_macros.svh"

module gctf_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic accel_used,
   input wire logic sample_taken
);

   // A result item that is not taken stays offered.
   `GCTF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result item dropped")

   // Only one sample is in work: accepting one closes the input.
   `GCTF_ASSERT(a_one_item, clock, reset, req_valid && req_ready |=> !req_ready, "second item accepted early")

   // A skipped sample never reports an accel correction.
   `GCTF_ASSERT(a_skip_flags, clock, reset, rsp_valid |-> !(accel_used && !sample_taken), "correction on skipped sample")

   // After reset the block is empty and open for input.
   `GCTF_ASSERT_ALWAYS(a_reset_state, clock, reset |=> (!rsp_valid && req_ready), "bad state after reset")

endmodule

bind gated_complementary_tilt_filter gctf_checker u_gctf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .accel_used   (rsp_chan.accel_used),
   .sample_taken (rsp_chan.sample_taken)
);

`default_nettype wire
